/* src/hwmon_reading_converter_defines.svh */
// assertion macros shared by the hwmon reading converter checker
`ifndef HWMON_READING_CONVERTER_DEFINES_SVH
`define HWMON_READING_CONVERTER_DEFINES_SVH

// property checked on every rising edge while out of reset
`define HRC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every rising edge, reset included
`define HRC_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/hrc_pkg.sv */
// types, constants and the divider step shared by the reading converter
`default_nettype none

package hrc_pkg;

  typedef enum logic [1:0] {
    KIND_VOLT = 2'd0,
    KIND_TEMP = 2'd1,
    KIND_FAN  = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_VOLT_EN     = 2'd0,
    REG_TEMP_CTL_LO = 2'd1,
    REG_TEMP_CTL_HI = 2'd2,
    REG_FAN_EN      = 2'd3
  } reg_index_t;

  localparam int unsigned READING_W     = 30;
  localparam int unsigned COUNT_W       = 12;
  localparam int unsigned QUOT_W        = 20;
  localparam int unsigned DIV_STEP_BITS = 4;
  localparam int unsigned DIV_STAGES    = QUOT_W / DIV_STEP_BITS;

  // 1350000 / (2 * count) is exactly 675000 / count
  localparam logic [QUOT_W-1:0] FAN_DIVIDEND = 20'd675000;

  // what travels beside the divisor through the divider
  typedef struct packed {
    logic                 is_fan;
    logic                 ok;
    logic [READING_W-1:0] value;
  } side_t;

  typedef struct packed {
    logic [COUNT_W-1:0]       rem;
    logic [DIV_STEP_BITS-1:0] q;
  } div_step_t;

  // restoring division over DIV_STEP_BITS quotient bits
  function automatic div_step_t div_step(input logic [COUNT_W-1:0] rem_in,
                                         input logic [COUNT_W-1:0] divisor,
                                         input logic [DIV_STEP_BITS-1:0] num);
    logic [COUNT_W:0]   trial;
    logic [COUNT_W-1:0] r;
    div_step_t          res;
    r     = rem_in;
    res.q = '0;
    for (int i = DIV_STEP_BITS - 1; i >= 0; i--) begin
      trial = {r, num[i]};
      if (trial >= {1'b0, divisor}) begin
        trial    = trial - {1'b0, divisor};
        res.q[i] = 1'b1;
      end
      r = trial[COUNT_W-1:0];
    end
    res.rem = r;
    return res;
  endfunction

endpackage

`default_nettype wire

/* src/hwmon_reading_converter.sv */
// hardware-monitor reading converter: raw sensor bytes to scaled readings
//
// Readings arrive on the s_ stream: s_tuser carries the sensor kind, s_tdata
// the channel and the two raw bytes. Each reading gives exactly one result on
// the m_ stream: m_tdata carries the signed 30-bit value (microvolts,
// micro-kelvin or rpm), m_tuser the valid flag. Disabled or out-of-range
// channels, kind 3, the temperature no-reading pattern and a zero fan count
// come out as value 0 with the flag clear.
// From input transfer to m_tvalid a reading passes one decode and scaling
// stage, five divider stages of four quotient bits each for the fan speed,
// and the output register. One reading is taken every cycle unless stalled.
// Every stage loads when empty or when its content moves on, so when the
// receiver stalls the pipeline fills up and s_tready falls only once all
// stages hold data; nothing is dropped or repeated.
// The cfg channel writes one of four enable registers by index and is always
// ready. Synchronous reset clears the enables and empties the pipeline.
`default_nettype none

module hwmon_reading_converter
  import hrc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // channel[3:0], raw_high[11:4], raw_low[19:12], zero pad
  input  logic [1:0]  s_tuser,   // kind[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // reading[29:0] signed, zero pad
  output logic        m_tuser,   // reading_valid[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_data
);

  logic [14:0] volt_en;
  logic [7:0]  tctl_lo;
  logic [7:0]  tctl_hi;
  logic [13:0] fan_en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      volt_en <= '0;
      tctl_lo <= '0;
      tctl_hi <= '0;
      fan_en  <= '0;
    end else if (cfg_valid) begin
      unique case (reg_index_t'(cfg_index))
        REG_VOLT_EN:     volt_en <= cfg_data;
        REG_TEMP_CTL_LO: tctl_lo <= cfg_data[7:0];
        REG_TEMP_CTL_HI: tctl_hi <= cfg_data[7:0];
        REG_FAN_EN:      fan_en  <= cfg_data[13:0];
      endcase
    end
  end

  // input fields
  logic [3:0] channel;
  logic [7:0] raw_high;
  logic [7:0] raw_low;

  assign channel  = s_tdata[3:0];
  assign raw_high = s_tdata[11:4];
  assign raw_low  = s_tdata[19:12];

  // enables widened so that out-of-range channels read as disabled
  logic [15:0] volt_en_ext;
  logic [15:0] fan_en_ext;
  logic [7:0]  temp_en;

  assign volt_en_ext = {1'b0, volt_en};
  assign fan_en_ext  = {2'b0, fan_en};
  assign temp_en     = {2'b0, tctl_hi[6], tctl_hi[4], tctl_hi[2], tctl_hi[0],
                        tctl_lo[2], tctl_lo[0]};

  logic [10:0]          volt_code;
  logic [23:0]          volt_prod;
  logic [READING_W-1:0] volt_value;
  logic [1:0]           temp_q;
  logic [READING_W-1:0] temp_value;
  logic                 temp_none;
  logic [COUNT_W-1:0]   fan_count;
  side_t                a_side_next;

  // main byte shifted up by three, bit 2 stays clear
  assign volt_code  = {raw_high, 1'b0, raw_low[7:6]};
  assign volt_prod  = {13'b0, volt_code} * ((channel >= 4'd12) ? 24'd6000 : 24'd2000);
  assign volt_value = 30'd10000000 - {6'b0, volt_prod};

  // signed whole degrees plus quarters, all modulo the reading width
  assign temp_q     = raw_low[7:6];
  assign temp_value = ({{(READING_W-8){raw_high[7]}}, raw_high} * 30'd1000000)
                    + ({28'b0, temp_q} * 30'd250000) + 30'd273150000;
  assign temp_none  = (raw_high == 8'h80) && (temp_q == 2'd0);

  assign fan_count = {raw_high, raw_low[7:4]};

  always_comb begin
    a_side_next = '0;
    unique case (kind_t'(s_tuser))
      KIND_VOLT: begin
        if (volt_en_ext[channel]) begin
          a_side_next.ok    = 1'b1;
          a_side_next.value = volt_value;
        end
      end
      KIND_TEMP: begin
        if (!channel[3] && temp_en[channel[2:0]] && !temp_none) begin
          a_side_next.ok    = 1'b1;
          a_side_next.value = temp_value;
        end
      end
      KIND_FAN: begin
        a_side_next.is_fan = 1'b1;
        a_side_next.ok     = fan_en_ext[channel] && (fan_count != '0);
      end
      default: a_side_next = '0;
    endcase
  end

  // decode and scaling stage
  logic               a_valid;
  side_t              a_side;
  logic [COUNT_W-1:0] a_count;
  logic               div_in_ready;
  logic               a_ready;

  assign a_ready  = !a_valid || div_in_ready;
  assign s_tready = a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && s_tvalid) begin
      a_side  <= a_side_next;
      a_count <= fan_count;
    end
  end

  logic              div_out_valid;
  logic              div_out_ready;
  logic [QUOT_W-1:0] div_quot;
  side_t             div_side;

  hrc_div u_div (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (a_valid),
    .in_ready   (div_in_ready),
    .in_divisor (a_count),
    .in_side    (a_side),
    .out_valid  (div_out_valid),
    .out_ready  (div_out_ready),
    .out_quot   (div_quot),
    .out_side   (div_side)
  );

  // output register
  logic [READING_W-1:0] reading;

  always_comb begin
    if (!div_side.ok) begin
      reading = '0;
    end else if (div_side.is_fan) begin
      reading = {{(READING_W-QUOT_W){1'b0}}, div_quot};
    end else begin
      reading = div_side.value;
    end
  end

  assign div_out_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (div_out_ready) begin
      m_tvalid <= div_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (div_out_ready && div_out_valid) begin
      m_tdata <= {2'b0, reading};
      m_tuser <= div_side.ok;
    end
  end

endmodule

`default_nettype wire

/* src/hrc_div.sv */
// pipelined constant-over-count divider, a few quotient bits per stage
`default_nettype none

module hrc_div
  import hrc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [COUNT_W-1:0] in_divisor,
  input  side_t              in_side,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [QUOT_W-1:0]  out_quot,
  output side_t              out_side
);

  logic [DIV_STAGES-1:0] v;
  logic [COUNT_W-1:0]    d    [DIV_STAGES];
  logic [COUNT_W-1:0]    rem  [DIV_STAGES];
  logic [QUOT_W-1:0]     q    [DIV_STAGES];
  side_t                 side [DIV_STAGES];

  // index 0 is the input, index k+1 is stage k
  logic [DIV_STAGES:0]   s_valid;
  logic [COUNT_W-1:0]    s_d    [DIV_STAGES+1];
  logic [COUNT_W-1:0]    s_rem  [DIV_STAGES+1];
  logic [QUOT_W-1:0]     s_q    [DIV_STAGES+1];
  side_t                 s_side [DIV_STAGES+1];
  logic [DIV_STAGES:0]   rdy;
  div_step_t             step   [DIV_STAGES];

  always_comb begin
    s_valid[0] = in_valid;
    s_d[0]     = in_divisor;
    s_rem[0]   = '0;
    s_q[0]     = '0;
    s_side[0]  = in_side;
    for (int k = 0; k < DIV_STAGES; k++) begin
      s_valid[k+1] = v[k];
      s_d[k+1]     = d[k];
      s_rem[k+1]   = rem[k];
      s_q[k+1]     = q[k];
      s_side[k+1]  = side[k];
    end
  end

  // a stage takes a new entry when empty or when its content moves on
  always_comb begin
    rdy[DIV_STAGES] = out_ready;
    for (int k = DIV_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end

  always_comb begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      step[k] = div_step(s_rem[k], s_d[k],
                         FAN_DIVIDEND[QUOT_W-1-k*DIV_STEP_BITS -: DIV_STEP_BITS]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        if (rdy[k]) begin
          v[k] <= s_valid[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (rdy[k] && s_valid[k]) begin
        d[k]    <= s_d[k];
        rem[k]  <= step[k].rem;
        q[k]    <= s_q[k] |
                   (QUOT_W'(step[k].q) << (QUOT_W - (k + 1) * DIV_STEP_BITS));
        side[k] <= s_side[k];
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = s_valid[DIV_STAGES];
  assign out_quot  = s_q[DIV_STAGES];
  assign out_side  = s_side[DIV_STAGES];

endmodule

`default_nettype wire

/* src/hrc_checker.sv */
// port-level checks for the reading converter, bound to the top level
`default_nettype none

`include "hwmon_reading_converter_defines.svh"

module hrc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tuser
);

  // reset leaves the pipeline empty and open
  `HRC_ASSERT_RST(a_reset_empty, rst |=> !m_tvalid && s_tready, "pipeline not empty after reset")

  // an invalid reading always carries a zero value and zero padding
  `HRC_ASSERT(a_invalid_zero, m_tvalid && !m_tuser |-> m_tdata == 32'd0, "invalid reading not zero")

  // with the output register empty every stage can take a reading
  `HRC_ASSERT(a_ready_when_drained, !m_tvalid |-> s_tready, "input stalled with empty output")

  // a stalled result holds
  `HRC_ASSERT(a_stall_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind hwmon_reading_converter hrc_checker u_hrc_checker (.*);

`default_nettype wire

/* verif/tb_top.sv */
// self-checking testbench for the hardware-monitor reading converter
module tb_top;
  import hrc_pkg::*;

  typedef struct packed {
    kind_t      kind;
    logic [3:0] channel;
    logic [7:0] raw_high;
    logic [7:0] raw_low;
  } sensor_reading_t;

  typedef struct packed {
    logic [READING_W-1:0] reading;
    logic                 reading_valid;
  } scaled_reading_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [14:0] cfg_data = '0;

  hwmon_reading_converter u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // local copy of the enable registers
  logic [14:0] volt_en_copy = '0;
  logic [7:0]  temp_ctl_lo_copy = '0;
  logic [7:0]  temp_ctl_hi_copy = '0;
  logic [13:0] fan_en_copy = '0;

  sensor_reading_t pending_readings[$];
  scaled_reading_t expected_readings[$];
  sensor_reading_t held_reading;

  int mismatches = 0;
  int readings_sent = 0;
  int results_checked = 0;
  int register_writes = 0;
  int valid_results = 0;

  // sender and receiver pacing, set per phase
  bit tx_steady = 1'b0;
  int rx_mode = 0;
  int burst_left = 0;
  int gap_left = 0;
  int run_left = 0;

  function automatic scaled_reading_t convert_reading(sensor_reading_t r);
    scaled_reading_t res;
    logic signed [31:0] value;
    logic [10:0] code;
    logic [11:0] count;
    logic [1:0] quarters;
    logic en;
    value = 0;
    res.reading_valid = 1'b0;
    case (r.kind)
      KIND_VOLT: begin
        if (r.channel != 4'd15 && volt_en_copy[r.channel]) begin
          code = {r.raw_high, 1'b0, r.raw_low[7:6]};
          if (r.channel >= 4'd12)
            value = 10000000 - int'(code) * 6000;
          else
            value = 10000000 - int'(code) * 2000;
          res.reading_valid = 1'b1;
        end
      end
      KIND_TEMP: begin
        if (r.channel <= 4'd5) begin
          if (r.channel < 4'd2)
            en = temp_ctl_lo_copy[2 * r.channel];
          else
            en = temp_ctl_hi_copy[2 * (r.channel - 2)];
          quarters = r.raw_low[7:6];
          // the no-reading pattern is -128 with no quarter degrees
          if (en && !(r.raw_high == 8'h80 && quarters == 2'd0)) begin
            value = int'($signed(r.raw_high)) * 1000000 + int'(quarters) * 250000
                    + 273150000;
            res.reading_valid = 1'b1;
          end
        end
      end
      KIND_FAN: begin
        if (r.channel <= 4'd13 && fan_en_copy[r.channel]) begin
          count = {r.raw_high, r.raw_low[7:4]};
          if (count != 12'd0) begin
            value = 1350000 / (2 * int'(count));
            res.reading_valid = 1'b1;
          end
        end
      end
      default: ;
    endcase
    res.reading = value[READING_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  // sender: bursts of transfers separated by random gaps, or back to back when tx_steady is set
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_readings.push_back(convert_reading(held_reading));
        readings_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (pending_readings.size() > 0) begin
          held_reading = pending_readings.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {4'b0, held_reading.raw_low, held_reading.raw_high,
                       held_reading.channel};
          s_tuser  <= held_reading.kind;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap_left   = tx_steady ? 0 : $urandom_range(0, 6);
          end else begin
            burst_left--;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each transfer and, unless rx_mode is 0, stalls in runs
  always @(posedge clk) begin
    scaled_reading_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        results_checked++;
        if (m_tuser)
          valid_results++;
        if (expected_readings.size() == 0) begin
          report_mismatch($sformatf("unexpected result reading=%0d valid=%0b",
                                    $signed(m_tdata[READING_W-1:0]), m_tuser));
        end else begin
          want = expected_readings.pop_front();
          if (m_tdata[READING_W-1:0] !== want.reading)
            report_mismatch($sformatf("reading got %0d want %0d",
                                      $signed(m_tdata[READING_W-1:0]),
                                      $signed(want.reading)));
          if (m_tuser !== want.reading_valid)
            report_mismatch($sformatf("reading_valid got %0b want %0b",
                                      m_tuser, want.reading_valid));
        end
      end
      if (rx_mode == 0) begin
        m_tready <= 1'b1;
      end else if (run_left == 0) begin
        // flip between ready and stalled runs
        if (m_tready)
          run_left = (rx_mode == 1) ? $urandom_range(1, 3) : $urandom_range(4, 12);
        else
          run_left = (rx_mode == 1) ? $urandom_range(1, 10) : $urandom_range(1, 3);
        m_tready <= !m_tready;
      end else begin
        run_left--;
      end
    end
  end

  task automatic write_register(input reg_index_t idx, input logic [14:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_VOLT_EN:     volt_en_copy     = val;
      REG_TEMP_CTL_LO: temp_ctl_lo_copy = val[7:0];
      REG_TEMP_CTL_HI: temp_ctl_hi_copy = val[7:0];
      REG_FAN_EN:      fan_en_copy      = val[13:0];
      default: ;
    endcase
    register_writes++;
  endtask

  task automatic set_enables(input logic [14:0] volt, input logic [7:0] tlo,
                             input logic [7:0] thi, input logic [13:0] fan);
    write_register(REG_VOLT_EN, volt);
    write_register(REG_TEMP_CTL_LO, {7'b0, tlo});
    write_register(REG_TEMP_CTL_HI, {7'b0, thi});
    write_register(REG_FAN_EN, {1'b0, fan});
  endtask

  task automatic wait_drained();
    while (pending_readings.size() != 0 || s_tvalid || expected_readings.size() != 0)
      @(posedge clk);
  endtask

  function automatic void queue_reading(input kind_t k, input logic [3:0] ch,
                                        input logic [7:0] hi, input logic [7:0] lo);
    sensor_reading_t r;
    r.kind = k;
    r.channel = ch;
    r.raw_high = hi;
    r.raw_low = lo;
    pending_readings.push_back(r);
  endfunction

  function automatic void queue_random_reading();
    sensor_reading_t r;
    int pick;
    pick = $urandom_range(0, 19);
    r.kind = pick < 6 ? KIND_VOLT : pick < 12 ? KIND_TEMP : pick < 18 ? KIND_FAN : KIND_NONE;
    if ($urandom_range(0, 3) == 0)
      r.channel = 4'($urandom_range(0, 15));
    else
      case (r.kind)
        KIND_VOLT: r.channel = 4'($urandom_range(0, 14));
        KIND_TEMP: r.channel = 4'($urandom_range(0, 5));
        KIND_FAN:  r.channel = 4'($urandom_range(0, 13));
        default:   r.channel = 4'($urandom_range(0, 15));
      endcase
    r.raw_high = 8'($urandom);
    r.raw_low  = 8'($urandom);
    case ($urandom_range(0, 9))
      0: begin
        r.raw_high = 8'h80;
        r.raw_low[7:6] = 2'd0;
      end
      1: begin
        // tiny or zero fan count
        r.raw_high = 8'h00;
        r.raw_low  = 8'($urandom_range(0, 31));
      end
      default: ;
    endcase
    pending_readings.push_back(r);
  endfunction

  task automatic run_random_phase(input int n, input bit steady, input int mode);
    tx_steady = steady;
    rx_mode = mode;
    repeat (n) queue_random_reading();
    wait_drained();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset enables: everything reads back invalid
    queue_reading(KIND_VOLT, 4'd0, 8'h12, 8'hc0);
    queue_reading(KIND_TEMP, 4'd0, 8'h19, 8'h40);
    queue_reading(KIND_FAN, 4'd0, 8'h10, 8'h00);
    queue_reading(KIND_NONE, 4'd0, 8'hff, 8'hff);
    wait_drained();

    set_enables(15'h7fff, 8'hff, 8'hff, 14'h3fff);
    rx_mode = 1;
    queue_reading(KIND_VOLT, 4'd0, 8'h00, 8'h00);
    queue_reading(KIND_VOLT, 4'd11, 8'hff, 8'hc0);
    queue_reading(KIND_VOLT, 4'd12, 8'hff, 8'hff);
    queue_reading(KIND_VOLT, 4'd14, 8'h00, 8'h3f);
    queue_reading(KIND_VOLT, 4'd15, 8'h55, 8'h80);
    queue_reading(KIND_TEMP, 4'd0, 8'h7f, 8'hc0);
    queue_reading(KIND_TEMP, 4'd1, 8'h80, 8'h3f);
    queue_reading(KIND_TEMP, 4'd2, 8'h80, 8'h40);
    queue_reading(KIND_TEMP, 4'd5, 8'h00, 8'h00);
    queue_reading(KIND_TEMP, 4'd6, 8'h20, 8'h00);
    queue_reading(KIND_TEMP, 4'd15, 8'hff, 8'hff);
    queue_reading(KIND_FAN, 4'd0, 8'h00, 8'h0f);
    queue_reading(KIND_FAN, 4'd1, 8'h00, 8'h10);
    queue_reading(KIND_FAN, 4'd7, 8'hff, 8'hff);
    queue_reading(KIND_FAN, 4'd13, 8'h05, 8'h30);
    queue_reading(KIND_FAN, 4'd14, 8'h05, 8'h30);
    queue_reading(KIND_FAN, 4'd15, 8'hff, 8'hf0);
    queue_reading(KIND_NONE, 4'd15, 8'h00, 8'h00);
    wait_drained();

    // disabled-channel checks: odd temperature bits do not enable anything
    set_enables(15'h2aaa, 8'haa, 8'haa, 14'h1555);
    queue_reading(KIND_VOLT, 4'd0, 8'h40, 8'h00);
    queue_reading(KIND_VOLT, 4'd1, 8'h40, 8'h00);
    queue_reading(KIND_TEMP, 4'd1, 8'h19, 8'h80);
    queue_reading(KIND_FAN, 4'd0, 8'h02, 8'h00);
    queue_reading(KIND_FAN, 4'd13, 8'h02, 8'h00);
    run_random_phase(45, 1'b0, 2);

    set_enables(15'h7fff, 8'hff, 8'hff, 14'h3fff);
    run_random_phase(60, 1'b1, 0);
    run_random_phase(50, 1'b0, 1);

    set_enables(15'h0000, 8'h00, 8'h00, 14'h0000);
    run_random_phase(30, 1'b0, 2);

    set_enables(15'h5555, 8'h55, 8'h55, 14'h2aaa);
    run_random_phase(50, 1'b1, 1);

    repeat (3) begin
      set_enables(15'($urandom), 8'($urandom), 8'($urandom), 14'($urandom));
      run_random_phase(50, 1'($urandom_range(0, 1)), int'($urandom_range(0, 2)));
    end

    // catch anything the block emits after the last expected result
    repeat (20) @(posedge clk);

    $display("%0d readings sent, %0d results checked (%0d valid), %0d register writes",
             readings_sent, results_checked, valid_results, register_writes);
    $display("kinds voltage, temperature, fan and unused over several enable settings");
    if (mismatches == 0 && expected_readings.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      if (expected_readings.size() != 0)
        report_mismatch($sformatf("%0d results never arrived", expected_readings.size()));
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout: %0d results still awaited", expected_readings.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
